>>> design/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
package tmcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF = 25;
   // Linear cell index; wide enough for the largest screen size
   localparam int LIN_W = 12;
   localparam int POS_W = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [15:0] BLANK_AT_RESET = 16'h0720;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL = 8'h7F;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN = 8'h0D;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] TAB_STEP = 8'd8;

   localparam logic [3:0] TEXT_COLOR_RESET = 4'd7;
   localparam logic [3:0] BACK_COLOR_RESET = 4'd0;
   localparam logic CSR_TEXT_COLOR = 1'b0;
   localparam logic CSR_BACK_COLOR = 1'b1;

   typedef enum logic [1:0] {
      OP_PUT = 2'd0,
      OP_SET = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CH_NEWLINE = 3'd0,
      CH_RETURN = 3'd1,
      CH_TAB = 3'd2,
      CH_PRINT = 3'd3,
      CH_IGNORE = 3'd4
   } char_class_type;

   typedef struct packed {
      op_type op;
      char_class_type cls;
      logic in_range;
      logic [7:0] char_code;
      logic [6:0] column;
      logic [4:0] row;
      logic [LIN_W-1:0] target;
      logic eow;
   } cmd_type;

   typedef struct packed {
      logic status;
      logic [POS_W-1:0] pos;
      logic update;
      logic [15:0] cell_data;
      logic scrolled;
   } result_type;

endpackage

>>> design/tmcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/tmcw_front.sv
// Front end: accept request items, classify them and queue them for the back end.
module tmcw_front import tmcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   input  logic                  init_busy,
   output logic                  q_valid,
   output cmd_type               q_cmd,
   input  logic                  q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type in_cmd;
   logic push;
   logic [7:0] ch;

   assign ch = req_tdata[7:0];

   always_comb begin
      in_cmd = '0;
      in_cmd.op = op_type'(req_tuser);
      in_cmd.char_code = ch;
      in_cmd.column = req_tdata[14:8];
      in_cmd.row = req_tdata[19:15];
      in_cmd.eow = req_tlast;
      in_cmd.in_range = (req_tdata[14:8] < 7'(COLUMNS)) && (req_tdata[19:15] < 5'(ROWS));
      in_cmd.target = LIN_W'(req_tdata[19:15]) * LIN_W'(COLUMNS) + LIN_W'(req_tdata[14:8]);
      if (ch == CHAR_NEWLINE) begin
         in_cmd.cls = CH_NEWLINE;
      end else if (ch == CHAR_RETURN) begin
         in_cmd.cls = CH_RETURN;
      end else if (ch == CHAR_TAB) begin
         in_cmd.cls = CH_TAB;
      end else if (ch inside {[CHAR_SPACE:CHAR_DEL]}) begin
         in_cmd.cls = CH_PRINT;
      end else begin
         in_cmd.cls = CH_IGNORE;
      end
   end

   assign req_tready = !init_busy && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push = req_tvalid && req_tready;
   assign q_valid = (count_ff != '0);
   assign q_cmd = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

>>> design/tmcw_back.sv
// Back end: cursor, screen store, scroll and clear sweeps, result register.
module tmcw_back import tmcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS = ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       init_busy,
   input  logic [7:0] attr,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_result
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam logic [LIN_W-1:0] LAST_CELL = LIN_W'(CELLS - 1);
   localparam logic [LIN_W-1:0] ROW_LEN = LIN_W'(COLUMNS);
   localparam logic [LIN_W-1:0] BOTTOM_ROW = LIN_W'(CELLS - COLUMNS);

   typedef enum logic [5:0] {
      ST_INIT = 6'b000001,
      ST_RUN = 6'b000010,
      ST_CLEAR = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_BLANK = 6'b010000,
      ST_READ = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [LIN_W-1:0] sweep_ff, sweep_in;
   logic [6:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic move_ff, move_in;
   logic [LIN_W-1:0] move_addr_ff, move_addr_in;

   logic ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0] ram_wdata, ram_rdata;
   logic [15:0] blank_cell;
   logic [LIN_W-1:0] cur_lin, put_lin;
   logic [7:0] tab_sum, put_col;
   logic [5:0] put_row;
   logic put_scroll;

   assign blank_cell = {attr, CHAR_SPACE};
   assign cur_lin = LIN_W'(row_ff) * ROW_LEN + LIN_W'(col_ff);
   assign tab_sum = {1'b0, col_ff} + TAB_STEP;

   // Cursor after a put-character: move, then wrap, then clamp on scroll
   always_comb begin
      put_col = {1'b0, col_ff};
      put_row = {1'b0, row_ff};
      put_scroll = 1'b0;
      case (q_cmd.cls)
         CH_NEWLINE: begin
            put_col = '0;
            put_row = {1'b0, row_ff} + 6'd1;
         end
         CH_RETURN: begin
            put_col = '0;
         end
         CH_TAB: begin
            put_col = {tab_sum[7:3], 3'b000};
         end
         CH_PRINT: begin
            put_col = {1'b0, col_ff} + 8'd1;
         end
         default: begin
         end
      endcase
      if (put_col >= 8'(COLUMNS)) begin
         put_col = '0;
         put_row = put_row + 6'd1;
      end
      if (put_row >= 6'(ROWS)) begin
         put_row = 6'(ROWS - 1);
         put_scroll = 1'b1;
      end
   end

   assign put_lin = LIN_W'(put_row[4:0]) * ROW_LEN + LIN_W'(put_col[6:0]);

   assign q_pop = (state_ff == ST_RUN) && q_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      col_in = col_ff;
      row_in = row_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      move_in = 1'b0;
      move_addr_in = sweep_ff - ROW_LEN;
      ram_we = 1'b0;
      ram_waddr = sweep_ff[AW-1:0];
      ram_wdata = blank_cell;
      ram_raddr = q_cmd.target[AW-1:0];
      case (state_ff)
         ST_INIT: begin
            ram_we = 1'b1;
            ram_wdata = BLANK_AT_RESET;
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_RUN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_RUN: begin
            if (q_pop) begin
               out_in = '0;
               out_in.pos = cur_lin[POS_W-1:0];
               case (q_cmd.op)
                  OP_PUT: begin
                     col_in = put_col[6:0];
                     row_in = put_row[4:0];
                     out_in.pos = put_lin[POS_W-1:0];
                     out_in.update = q_cmd.eow;
                     if (q_cmd.cls == CH_PRINT) begin
                        ram_we = 1'b1;
                        ram_waddr = cur_lin[AW-1:0];
                        ram_wdata = {attr, q_cmd.char_code};
                     end
                     if (put_scroll) begin
                        out_in.scrolled = 1'b1;
                        state_in = ST_SCROLL;
                        sweep_in = ROW_LEN;
                     end else begin
                        out_valid_in = 1'b1;
                     end
                  end
                  OP_SET: begin
                     if (q_cmd.in_range) begin
                        col_in = q_cmd.column;
                        row_in = q_cmd.row;
                        out_in.pos = q_cmd.target[POS_W-1:0];
                        out_in.update = 1'b1;
                     end else begin
                        out_in.status = 1'b1;
                     end
                     out_valid_in = 1'b1;
                  end
                  OP_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                     out_in.pos = '0;
                     out_in.update = 1'b1;
                     state_in = ST_CLEAR;
                     sweep_in = '0;
                  end
                  OP_READ: begin
                     if (q_cmd.in_range) begin
                        state_in = ST_READ;
                     end else begin
                        out_in.status = 1'b1;
                        out_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_RUN;
               out_valid_in = 1'b1;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_SCROLL: begin
            // Read one row down now, write it back one row up next cycle
            ram_raddr = sweep_ff[AW-1:0];
            move_in = 1'b1;
            if (move_ff) begin
               ram_we = 1'b1;
               ram_waddr = move_addr_ff[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_BLANK;
               sweep_in = BOTTOM_ROW;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            // Finish the last pending move before blanking the bottom row
            if (move_ff) begin
               ram_we = 1'b1;
               ram_waddr = move_addr_ff[AW-1:0];
               ram_wdata = ram_rdata;
            end else begin
               ram_we = 1'b1;
               if (sweep_ff == LAST_CELL) begin
                  state_in = ST_RUN;
                  out_valid_in = 1'b1;
               end else begin
                  sweep_in = sweep_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            out_in.cell_data = ram_rdata;
            out_valid_in = 1'b1;
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_INIT;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         out_valid_ff <= 1'b0;
         move_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         col_ff <= col_in;
         row_ff <= row_in;
         out_valid_ff <= out_valid_in;
         move_ff <= move_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      move_addr_ff <= move_addr_in;
   end

   tmcw_ram #(
      .WIDTH(16),
      .DEPTH(CELLS)
   ) u_screen (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign init_busy = (state_ff == ST_INIT);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < 7'(COLUMNS) && row_ff < 5'(ROWS))
      else $error("cursor outside the screen");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !out_valid_ff)
      else $error("result pending during a multi-cycle operation");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !ram_we)
      else $error("screen written during a cell read");

   a_move_follows_scroll: assert property (@(posedge clock) disable iff (reset)
      move_ff |-> state_ff == ST_SCROLL || state_ff == ST_BLANK)
      else $error("row move outside a scroll");

endmodule

>>> design/text_mode_console_writer.sv
// Top level of the text-mode console writer: ports, color registers, front and back ends.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata char,column,row; tuser opcode; tlast
//   rsp      out        rsp_tvalid/rsp_tready  tdata pos,update,cell,scrolled; tuser status
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Put, set cursor and out-of-range reads complete in the back end from ST_RUN; an in-range read
// also passes through ST_READ, for the registered read port of the screen store.
// A put that scrolls walks the store one cell a cycle, moving each row up one row, then blanks
// the bottom row; clear walks the whole store, blanking every cell.
// After reset every cell of the store is blanked while req_tready is held low; csr writes are
// taken at all times. A two-entry queue decouples req from the back end; a result waiting on
// rsp_tready holds the back end until it is taken.
module text_mode_console_writer import tmcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_code[7:0], column[14:8], row[19:15], zero
   input  logic [1:0]            req_tuser,  // opcode[1:0]
   input  logic                  req_tlast,  // end_of_write
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_pos[10:0], cursor_update[11], cell_data[27:12], scrolled[28], zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,  // status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata
);

   logic [3:0] text_color_ff, text_color_in;
   logic [3:0] back_color_ff, back_color_in;
   logic q_valid, q_pop, init_busy;
   cmd_type q_cmd;
   result_type rsp_result;

   assign csr_ready = 1'b1;

   always_comb begin
      text_color_in = text_color_ff;
      back_color_in = back_color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEXT_COLOR: text_color_in = csr_wdata;
            CSR_BACK_COLOR: back_color_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RESET;
         back_color_ff <= BACK_COLOR_RESET;
      end else begin
         text_color_ff <= text_color_in;
         back_color_ff <= back_color_in;
      end
   end

   tmcw_front #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .init_busy(init_busy),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop)
   );

   tmcw_back #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop),
      .init_busy(init_busy),
      .attr({back_color_ff, text_color_ff}),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_result(rsp_result)
   );

   assign rsp_tdata = {3'b000, rsp_result.scrolled, rsp_result.cell_data, rsp_result.update,
                       rsp_result.pos};
   assign rsp_tuser = rsp_result.status;

endmodule
